### sv/ecf_pkg.sv
// Shared types, constants and the quarter-wave sine table for the easing-curve interpolator.
// Used by every module of the block; no dependencies of its own.
`default_nettype none
package ecf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TICK_W      = 24;
  localparam int POS_W       = 16;
  localparam int KIND_W      = 4;
  localparam int SINE_DEPTH  = 256;
  localparam int SINE_LOG2   = $clog2(SINE_DEPTH);
  // input regs, decode, divider, bounce, two passes, three tail stages
  localparam int LATENCY     = FRAC_BITS + 10;

  typedef logic [FRAC_BITS:0] qval_t;
  localparam qval_t Q_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam qval_t Q_HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [KIND_W-1:0] {
    CK_CONST, CK_LINEAR, CK_IN, CK_OUT, CK_INOUT, CK_INOUT_WEAK, CK_FAST,
    CK_FAST_WEAK, CK_BOUNCE, CK_BOUNCE_FAST, CK_BOUNCE_SLOW, CK_SINE, CK_SINE_EASED
  } curve_t;

  typedef enum logic [2:0] {OP_NONE, OP_QUAD, OP_INVQ, OP_S, OP_IQS} pass_op_t;

  typedef struct packed {
    logic [TICK_W-1:0]       tick_start;
    logic [TICK_W-1:0]       tick_end;
    logic [TICK_W-1:0]       tick_now;
    logic signed [POS_W-1:0] pos_start;
    logic signed [POS_W-1:0] pos_end;
    logic [KIND_W-1:0]       curve_kind;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    bad_curve;
  } out_t;

  // control that travels with each transaction through the pipeline
  typedef struct packed {
    logic                    bad;
    logic                    early;
    logic                    use_end;
    logic signed [POS_W-1:0] pos_start;
    logic signed [POS_W-1:0] pos_end;
    pass_op_t                op1;
    pass_op_t                op2;
    logic                    bounce;
    logic                    sine;
    logic                    zero;
  } side_t;

  typedef qval_t sine_tab_t [0:SINE_DEPTH];

  // sin(pi/2 * k / depth) by Taylor series in Q2.30, rounded to Q(FRAC_BITS);
  // term n is divided by (2n)(2n+1), once a term reaches zero the rest stay zero
  function automatic sine_tab_t sine_build();
    sine_tab_t         tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   v;
    longint            sum;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) >> SINE_LOG2;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd506; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd600; sum = sum + longint'(term);
      if (sum < 0) sum = 0;
      v = (longint'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (v > longint'(Q_ONE)) v = longint'(Q_ONE);
      tab[k] = v[FRAC_BITS:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = sine_build();

endpackage
`default_nettype wire

### sv/ecf_div.sv
// Pipelined restoring divider: one quotient bit per stage, (an << FRAC_BITS) / ad with an < ad.
// Depends on ecf_pkg.
`default_nettype none
module ecf_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [ecf_pkg::TICK_W-1:0]    in_an,
  input  wire logic [ecf_pkg::TICK_W-1:0]    in_ad,
  input  wire ecf_pkg::side_t                in_side,
  output logic                               out_vld,
  output logic [ecf_pkg::FRAC_BITS-1:0]      out_quo,
  output ecf_pkg::side_t                     out_side
);

  localparam int NST = ecf_pkg::FRAC_BITS;
  localparam int TW  = ecf_pkg::TICK_W;

  logic                  vld_r  [0:NST-1];
  logic [TW-1:0]         rem_r  [0:NST-1];
  logic [TW-1:0]         ad_r   [0:NST-1];
  logic [NST-1:0]        quo_r  [0:NST-1];
  ecf_pkg::side_t        side_r [0:NST-1];

  for (genvar j = 0; j < NST; j++) begin : g_st
    logic                vld_src;
    logic [TW-1:0]       rem_src;
    logic [TW-1:0]       ad_src;
    logic [NST-1:0]      quo_src;
    ecf_pkg::side_t      side_src;
    logic [TW:0]         r2;
    logic [TW:0]         sub;
    logic                ge;

    if (j == 0) begin : g_first
      assign vld_src  = in_vld;
      assign rem_src  = in_an;
      assign ad_src   = in_ad;
      assign quo_src  = '0;
      assign side_src = in_side;
    end else begin : g_rest
      assign vld_src  = vld_r[j-1];
      assign rem_src  = rem_r[j-1];
      assign ad_src   = ad_r[j-1];
      assign quo_src  = quo_r[j-1];
      assign side_src = side_r[j-1];
    end

    assign r2  = {rem_src, 1'b0};
    assign ge  = r2 >= {1'b0, ad_src};
    assign sub = r2 - {1'b0, ad_src};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= ge ? sub[TW-1:0] : r2[TW-1:0];
      ad_r[j]   <= ad_src;
      quo_r[j]  <= {quo_src[NST-2:0], ge};
      side_r[j] <= side_src;
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_quo  = quo_r[NST-1];
  assign out_side = side_r[NST-1];

endmodule
`default_nettype wire

### sv/ecf_pass.sv
// One easing pass over a Q1.16 value: quad, inverse quad, S curve, split inverse-quad S, or pass-through.
// Two register stages, one multiplier each. Depends on ecf_pkg.
`default_nettype none
module ecf_pass (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire ecf_pkg::qval_t     in_u,
  input  wire ecf_pkg::pass_op_t  in_op,
  input  wire ecf_pkg::side_t     in_side,
  output logic                    out_vld,
  output ecf_pkg::qval_t          out_u,
  output ecf_pkg::side_t          out_side
);

  localparam int FB = ecf_pkg::FRAC_BITS;
  localparam int W1 = 2 * FB + 4;
  localparam int W2 = 2 * FB + 5;

  // stage 1: first product
  logic [FB:0]         a_op;
  logic [FB+1:0]       b_op;
  logic [W1-1:0]       prod1;
  logic [W1-1:0]       rnd1;
  logic [FB+1:0]       two_u;
  logic                lo_nxt;
  ecf_pkg::qval_t      m1_nxt;

  logic                vld1_r;
  ecf_pkg::qval_t      m1_r;
  ecf_pkg::qval_t      u1_r;
  ecf_pkg::pass_op_t   op1_r;
  logic                lo1_r;
  ecf_pkg::side_t      side1_r;

  assign two_u  = {in_u, 1'b0};
  assign lo_nxt = in_u <= ecf_pkg::Q_HALF;

  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (in_op)
      ecf_pkg::OP_QUAD, ecf_pkg::OP_S: begin
        a_op = in_u;
        b_op = {1'b0, in_u};
      end
      ecf_pkg::OP_INVQ: begin
        a_op = in_u;
        b_op = {ecf_pkg::Q_ONE, 1'b0} - {1'b0, in_u};
      end
      ecf_pkg::OP_IQS: begin
        if (lo_nxt) begin
          a_op = two_u[FB:0];
          b_op = {ecf_pkg::Q_ONE, 1'b0} - two_u;
        end else begin
          a_op = two_u[FB:0] - ecf_pkg::Q_ONE;
          b_op = {1'b0, two_u[FB:0] - ecf_pkg::Q_ONE};
        end
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod1  = W1'(a_op) * W1'(b_op);
  assign rnd1   = prod1 + W1'(ecf_pkg::Q_HALF);
  assign m1_nxt = rnd1[2*FB:FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= m1_nxt;
    u1_r    <= in_u;
    op1_r   <= in_op;
    lo1_r   <= lo_nxt;
    side1_r <= in_side;
  end

  // stage 2: S-curve second product, clamps and halving
  logic [FB+2:0]       b2;
  logic [W2-1:0]       prod2;
  logic [W2-1:0]       rnd2;
  logic [FB+4:0]       m2;
  ecf_pkg::qval_t      c1;
  ecf_pkg::qval_t      hq;
  ecf_pkg::qval_t      u2_nxt;

  logic                vld2_r;
  ecf_pkg::qval_t      u2_r;
  ecf_pkg::side_t      side2_r;

  assign b2    = ((FB + 3)'(3) << FB) - {1'b0, u1_r, 1'b0};
  assign prod2 = W2'(m1_r) * W2'(b2);
  assign rnd2  = prod2 + W2'(ecf_pkg::Q_HALF);
  assign m2    = rnd2[2*FB+4:FB];
  assign c1    = (m1_r > ecf_pkg::Q_ONE) ? ecf_pkg::Q_ONE : m1_r;
  assign hq    = (c1 + 1'b1) >> 1;

  always_comb begin
    unique case (op1_r)
      ecf_pkg::OP_QUAD, ecf_pkg::OP_INVQ: u2_nxt = c1;
      ecf_pkg::OP_S: u2_nxt = (m2 > (FB + 5)'(ecf_pkg::Q_ONE)) ? ecf_pkg::Q_ONE : m2[FB:0];
      ecf_pkg::OP_IQS: u2_nxt = lo1_r ? hq : hq + ecf_pkg::Q_HALF;
      default: u2_nxt = u1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    u2_r    <= u2_nxt;
    side2_r <= side1_r;
  end

  assign out_vld  = vld2_r;
  assign out_u    = u2_r;
  assign out_side = side2_r;

endmodule
`default_nettype wire

### sv/ecf_tail.sv
// Sine lookup, position interpolation, rounding and saturation: three register stages.
// Depends on ecf_pkg (sine table, side_t, out_t).
`default_nettype none
module ecf_tail (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire ecf_pkg::qval_t   in_u,
  input  wire ecf_pkg::side_t   in_side,
  output logic                  out_vld,
  output ecf_pkg::out_t         out_item
);

  localparam int FB = ecf_pkg::FRAC_BITS;
  localparam int LG = ecf_pkg::SINE_LOG2;
  localparam int SH = LG + 2;
  localparam int AW = FB + SH + 2;
  localparam int PW = 2 * FB + 4;
  localparam int RW = PW - FB + 1;

  // stage A: warp value select
  logic [AW-1:0]               a_wide;
  logic [SH:0]                 a_idx;
  logic [2:0]                  quad;
  logic [LG-1:0]               rem;
  logic [LG:0]                 tidx;
  ecf_pkg::qval_t              mag;
  logic signed [FB+1:0]        sw;
  logic signed [FB+1:0]        w_nxt;
  logic signed [ecf_pkg::POS_W:0] diff_nxt;

  logic                        vlda_r;
  logic signed [FB+1:0]        w_r;
  logic signed [ecf_pkg::POS_W:0] diff_r;
  ecf_pkg::side_t              sidea_r;

  assign a_wide = ({(AW - FB - 1)'(0), in_u} << SH) + AW'(ecf_pkg::Q_HALF);
  assign a_idx  = a_wide[FB+SH:FB];
  assign quad   = a_idx[SH:LG];
  assign rem    = a_idx[LG-1:0];
  assign tidx   = (quad[0]) ? (LG + 1)'(ecf_pkg::SINE_DEPTH) - {1'b0, rem} : {1'b0, rem};
  assign mag    = ecf_pkg::SINE_TAB[tidx];

  always_comb begin
    unique case (quad)
      3'd0, 3'd1: sw = $signed({1'b0, mag});
      3'd2, 3'd3: sw = -$signed({1'b0, mag});
      default:    sw = '0;
    endcase
  end

  always_comb begin
    priority if (in_side.zero) w_nxt = '0;
    else if (in_side.sine) w_nxt = sw;
    else w_nxt = $signed({1'b0, in_u});
  end

  assign diff_nxt = {in_side.pos_end[ecf_pkg::POS_W-1], in_side.pos_end}
                  - {in_side.pos_start[ecf_pkg::POS_W-1], in_side.pos_start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r <= 1'b0;
    end else begin
      vlda_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    diff_r  <= diff_nxt;
    sidea_r <= in_side;
  end

  // stage B: product with rounding bias
  logic signed [PW-1:0]        ext_d;
  logic signed [PW-1:0]        ext_w;
  logic signed [PW-1:0]        prod_nxt;

  logic                        vldb_r;
  logic signed [PW-1:0]        prod_r;
  ecf_pkg::side_t              sideb_r;

  assign ext_d    = PW'(diff_r);
  assign ext_w    = PW'(w_r);
  assign prod_nxt = ext_d * ext_w + $signed(PW'(ecf_pkg::Q_HALF));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldb_r <= 1'b0;
    end else begin
      vldb_r <= vlda_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    sideb_r <= sidea_r;
  end

  // stage C: floor shift, add start, saturate, special cases
  logic signed [RW-1:0]        shifted;
  logic signed [RW-1:0]        sum;
  logic signed [ecf_pkg::POS_W-1:0] sat;
  ecf_pkg::out_t               item_nxt;

  logic                        vldc_r;
  ecf_pkg::out_t               item_r;

  assign shifted = RW'(prod_r >>> FB);
  assign sum     = shifted + RW'(sideb_r.pos_start);

  always_comb begin
    priority if (sum > RW'(32767)) sat = 16'sh7fff;
    else if (sum < -RW'(32768)) sat = -16'sh8000;
    else sat = sum[ecf_pkg::POS_W-1:0];
  end

  always_comb begin
    item_nxt.bad_curve = sideb_r.bad;
    priority if (sideb_r.bad) item_nxt.position = '1;
    else if (sideb_r.early) item_nxt.position = sideb_r.use_end ? sideb_r.pos_end
                                                                : sideb_r.pos_start;
    else item_nxt.position = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldc_r <= 1'b0;
    end else begin
      vldc_r <= vldb_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_vld  = vldc_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

### sv/animation_easing_curve_interpolator.sv
// Easing-curve interpolator top level: tick fraction, easing passes, interpolation.
// The quotient stages dominate the pipeline from start to out_valid.
// Throughput: one transaction per cycle; busy is low whenever out of reset.
// Reset (rst_n low, synchronous) clears every valid bit; busy is high while in reset.
// Depends on ecf_pkg, ecf_div, ecf_pass, ecf_tail.
`default_nettype none
module animation_easing_curve_interpolator (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ecf_pkg::in_t  in_item,
  output logic               out_valid,
  output ecf_pkg::out_t      out_item
);

  localparam int TW = ecf_pkg::TICK_W;
  localparam int FB = ecf_pkg::FRAC_BITS;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // stage 0: tick differences
  logic                      vld0_r;
  logic signed [TW:0]        num_r;
  logic signed [TW:0]        den_r;
  logic signed [ecf_pkg::POS_W-1:0] ps0_r;
  logic signed [ecf_pkg::POS_W-1:0] pe0_r;
  logic [ecf_pkg::KIND_W-1:0] kind0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= $signed({1'b0, in_item.tick_now}) - $signed({1'b0, in_item.tick_start});
    den_r   <= $signed({1'b0, in_item.tick_end}) - $signed({1'b0, in_item.tick_start});
    ps0_r   <= in_item.pos_start;
    pe0_r   <= in_item.pos_end;
    kind0_r <= in_item.curve_kind;
  end

  // stage 1: magnitudes, range cases, curve decode
  logic [TW:0]     an_full;
  logic [TW:0]     ad_full;
  logic            den_zero;
  logic            before_start;
  ecf_pkg::side_t  side_nxt;

  assign an_full      = num_r[TW] ? -num_r : num_r;
  assign ad_full      = den_r[TW] ? -den_r : den_r;
  assign den_zero     = den_r == '0;
  assign before_start = !den_zero && (num_r == '0 || num_r[TW] != den_r[TW]);

  always_comb begin
    side_nxt           = '0;
    side_nxt.pos_start = ps0_r;
    side_nxt.pos_end   = pe0_r;
    side_nxt.op1       = ecf_pkg::OP_NONE;
    side_nxt.op2       = ecf_pkg::OP_NONE;
    unique case (kind0_r)
      ecf_pkg::CK_CONST:       side_nxt.zero = 1'b1;
      ecf_pkg::CK_LINEAR:      side_nxt.op1 = ecf_pkg::OP_NONE;
      ecf_pkg::CK_IN:          side_nxt.op1 = ecf_pkg::OP_QUAD;
      ecf_pkg::CK_OUT:         side_nxt.op1 = ecf_pkg::OP_INVQ;
      ecf_pkg::CK_INOUT: begin
        side_nxt.op1 = ecf_pkg::OP_S;
        side_nxt.op2 = ecf_pkg::OP_S;
      end
      ecf_pkg::CK_INOUT_WEAK:  side_nxt.op1 = ecf_pkg::OP_S;
      ecf_pkg::CK_FAST: begin
        side_nxt.op1 = ecf_pkg::OP_IQS;
        side_nxt.op2 = ecf_pkg::OP_IQS;
      end
      ecf_pkg::CK_FAST_WEAK:   side_nxt.op1 = ecf_pkg::OP_IQS;
      ecf_pkg::CK_BOUNCE:      side_nxt.bounce = 1'b1;
      ecf_pkg::CK_BOUNCE_FAST: begin
        side_nxt.bounce = 1'b1;
        side_nxt.op1    = ecf_pkg::OP_QUAD;
      end
      ecf_pkg::CK_BOUNCE_SLOW: begin
        side_nxt.bounce = 1'b1;
        side_nxt.op1    = ecf_pkg::OP_INVQ;
      end
      ecf_pkg::CK_SINE:        side_nxt.sine = 1'b1;
      ecf_pkg::CK_SINE_EASED: begin
        side_nxt.sine = 1'b1;
        side_nxt.op1  = ecf_pkg::OP_S;
      end
      default:                 side_nxt.bad = 1'b1;
    endcase
    // at or past the end: bounce and sine curves return to the start
    side_nxt.use_end = !before_start && kind0_r < ecf_pkg::CK_BOUNCE;
    side_nxt.early   = before_start || den_zero || an_full >= ad_full;
  end

  logic            vld1_r;
  logic [TW-1:0]   an_r;
  logic [TW-1:0]   ad_r;
  ecf_pkg::side_t  side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    an_r    <= an_full[TW-1:0];
    ad_r    <= ad_full[TW-1:0];
    side1_r <= side_nxt;
  end

  // fraction
  logic            div_vld;
  logic [FB-1:0]   div_quo;
  ecf_pkg::side_t  div_side;

  ecf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld1_r),
    .in_an    (an_r),
    .in_ad    (ad_r),
    .in_side  (side1_r),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // bounce fold
  ecf_pkg::qval_t  t_ext;
  ecf_pkg::qval_t  t2;
  ecf_pkg::qval_t  u0_nxt;
  logic            vldp_r;
  ecf_pkg::qval_t  u0_r;
  ecf_pkg::side_t  sidep_r;

  assign t_ext  = {1'b0, div_quo};
  assign t2     = {div_quo, 1'b0};
  assign u0_nxt = !div_side.bounce ? t_ext
                : (t_ext <= ecf_pkg::Q_HALF) ? t2
                : ecf_pkg::qval_t'({ecf_pkg::Q_ONE, 1'b0} - {1'b0, t2});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldp_r <= 1'b0;
    end else begin
      vldp_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    u0_r    <= u0_nxt;
    sidep_r <= div_side;
  end

  // two easing passes
  logic            p1_vld;
  ecf_pkg::qval_t  p1_u;
  ecf_pkg::side_t  p1_side;
  logic            p2_vld;
  ecf_pkg::qval_t  p2_u;
  ecf_pkg::side_t  p2_side;

  ecf_pass u_pass1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vldp_r),
    .in_u     (u0_r),
    .in_op    (sidep_r.op1),
    .in_side  (sidep_r),
    .out_vld  (p1_vld),
    .out_u    (p1_u),
    .out_side (p1_side)
  );

  ecf_pass u_pass2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p1_vld),
    .in_u     (p1_u),
    .in_op    (p1_side.op2),
    .in_side  (p1_side),
    .out_vld  (p2_vld),
    .out_u    (p2_u),
    .out_side (p2_side)
  );

  ecf_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p2_vld),
    .in_u     (p2_u),
    .in_side  (p2_side),
    .out_vld  (out_valid),
    .out_item (out_item)
  );

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(ecf_pkg::LATENCY) out_valid)
    else $error("result strobe does not match accepted transaction");

  a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.bad_curve ==
      ($past(in_item.curve_kind, ecf_pkg::LATENCY) > ecf_pkg::CK_SINE_EASED))
    else $error("bad curve flag does not follow curve code");

  a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.bad_curve |-> out_item.position == '1)
    else $error("bad curve result is not -1");

endmodule
`default_nettype wire
